### rtl/bellman_ford_shortest_paths_defines.svh
// Assertion macros shared by the shortest path block.
`ifndef BELLMAN_FORD_SHORTEST_PATHS_DEFINES_SVH
`define BELLMAN_FORD_SHORTEST_PATHS_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BFSP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define BFSP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/bfsp_pkg.sv
// Types and constants of the shortest path block.
package bfsp_pkg;
	localparam int DIST_W = 21;
	localparam int VTX_W = 4;
	localparam int WIN_W = 16;
	localparam int CFG_W = 5;
	localparam logic signed [DIST_W-1:0] DIST_MAX = 21'sh0FFFFF;
	localparam logic signed [DIST_W-1:0] DIST_MIN = 21'sh100000;
	localparam logic [CFG_W-1:0] VC_RESET = 5'd16;
	localparam logic REG_VERTEX_COUNT = 1'b0;
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_RUN = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INIT,
		ST_RELAX,
		ST_CHECK,
		ST_EM_RD,
		ST_EM_LD,
		ST_NEG,
		ST_WAIT
	} state_t;
endpackage

### rtl/bfsp_if.sv
// Handshake channels for edge/run items and per-vertex results.
interface bfsp_item_if import bfsp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              func;
	logic [VTX_W-1:0]  from_vertex;
	logic [VTX_W-1:0]  to_vertex;
	logic signed [WIN_W-1:0] edge_weight;
	logic              edge_present;
	logic [VTX_W-1:0]  source_vertex;

	modport source (output valid, func, from_vertex, to_vertex, edge_weight, edge_present,
		source_vertex, input ready);
	modport sink (input valid, func, from_vertex, to_vertex, edge_weight, edge_present,
		source_vertex, output ready);
endinterface

interface bfsp_result_if import bfsp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [VTX_W-1:0]  vertex;
	logic signed [DIST_W-1:0] distance;
	logic              reachable;
	logic [VTX_W-1:0]  predecessor;
	logic              negative_cycle;
	logic              last;

	modport source (output valid, vertex, distance, reachable, predecessor, negative_cycle,
		last, input ready);
	modport sink (input valid, vertex, distance, reachable, predecessor, negative_cycle,
		last, output ready);
endinterface

### rtl/bfsp_ram.sv
// Generic simple dual-port RAM with registered read.
module bfsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### rtl/bellman_ford_shortest_paths.sv
// Top level: sequencer and shared relax unit of the shortest path block.
//
// item channel: a load beat (func = 0) writes one adjacency entry; a run beat
// (func = 1) starts a search from source_vertex. item.ready
// is high only while the block is idle.
// result channel: a run gives either one beat with negative_cycle and last set,
// or one beat per vertex 0 .. n-1 in order, last on the final one.
// Sequence for n vertices in use: init writes one distance per vertex, then
// n-1 relax rounds and one check pass, each made of one adjacency read and one
// distance read per compare-add step through the single shared relax unit.
// Each result then passes a read, a load and a wait state, held while stalled.
// Reset: a clearing pass writes every adjacency entry, one per cycle
// (2^(2*clog2(MAX_VERTICES)) entries, 256 by default); no item is taken then.
// A stalled receiver holds the result register; nothing is lost.
// Configuration: APB register vertex_count at byte address 0.
module bellman_ford_shortest_paths import bfsp_pkg::*; #(
	parameter int MAX_VERTICES = 16,
	parameter int WEIGHT_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	bfsp_item_if.sink    item,
	bfsp_result_if.source result,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	`include "bellman_ford_shortest_paths_defines.svh"

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int NW = VW + 1;
	localparam int KW = VW + 2;
	localparam int EAW = 2 * VW;
	localparam int EDEPTH = 1 << EAW;
	localparam int DAW = VW + 1;
	localparam int DDEPTH = 1 << DAW;
	localparam int SW = (WEIGHT_BITS < WIN_W) ? WEIGHT_BITS : WIN_W;
	localparam int EW = SW + 1;
	localparam int DW = 1 + DIST_W + VW;
	localparam int XW = VW + VTX_W;

	state_t state_q, state_d;

	logic [CFG_W-1:0] vc_q;
	logic [EAW-1:0]   clr_q;
	logic [VW-1:0]    v_q;
	logic [KW-1:0]    k_q;
	logic [VW-1:0]    r_q;
	logic             lay_q;
	logic [VTX_W-1:0] src_q;
	logic             neg_q;
	logic             pv_s1;
	logic             phead_s1;
	logic [VW-1:0]    pu_s1;
	logic signed [DIST_W-1:0] cur_dist_q;
	logic             cur_reach_q;
	logic [VW-1:0]    cur_pred_q;
	logic             out_valid_q;
	logic [VTX_W-1:0] out_vertex_q;
	logic signed [DIST_W-1:0] out_dist_q;
	logic             out_reach_q;
	logic [VTX_W-1:0] out_pred_q;
	logic             out_neg_q;
	logic             out_last_q;

	logic             e_we;
	logic [EAW-1:0]   e_waddr, e_raddr;
	logic [EW-1:0]    e_wdata, e_rdata;
	logic             d_we;
	logic [DAW-1:0]   d_waddr, d_raddr;
	logic [DW-1:0]    d_wdata, d_rdata;

	bfsp_ram #(.WIDTH(EW), .DEPTH(EDEPTH)) u_edge_ram (
		.clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
		.raddr(e_raddr), .rdata(e_rdata)
	);

	bfsp_ram #(.WIDTH(DW), .DEPTH(DDEPTH)) u_dist_ram (
		.clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
		.raddr(d_raddr), .rdata(d_rdata)
	);

	// configuration port
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_VERTEX_COUNT);
	assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? {{(32-CFG_W){1'b0}}, vc_q} : 32'd0;

	// clamp vertex count into 1 .. MAX_VERTICES
	logic [6:0]    vc7;
	logic [NW-1:0] n_eff, nm1;
	logic [KW-1:0] kn, k_end, km1;
	logic [VW-1:0] u_iss;
	logic          v_last, k_done, issue, round_last;
	logic [NW-1:0] r_next;

	always_comb begin
		vc7 = {2'b00, vc_q};
		if (vc7 == 7'd0) begin
			n_eff = NW'(1);
		end else if (vc7 > 7'(MAX_VERTICES)) begin
			n_eff = NW'(MAX_VERTICES);
		end else begin
			n_eff = vc7[NW-1:0];
		end
		nm1 = n_eff - NW'(1);
		kn = {1'b0, n_eff};
		k_end = kn + KW'(2);
		km1 = k_q - KW'(1);
		u_iss = km1[VW-1:0];
		v_last = ({1'b0, v_q} == nm1);
		k_done = (k_q == k_end);
		issue = (k_q <= kn);
		r_next = {1'b0, r_q} + NW'(1);
		round_last = (r_next == nm1);
	end

	// input field widening
	logic [XW-1:0] from_w, to_w, src_w, v_w, pred_w;
	logic          edge_in_range, is_src;
	always_comb begin
		from_w = {{VW{1'b0}}, item.from_vertex};
		to_w = {{VW{1'b0}}, item.to_vertex};
		src_w = {{VW{1'b0}}, src_q};
		v_w = {{VTX_W{1'b0}}, v_q};
		pred_w = {{VTX_W{1'b0}}, d_rdata[VW-1:0]};
		edge_in_range = (from_w < XW'(MAX_VERTICES)) && (to_w < XW'(MAX_VERTICES));
		is_src = (v_w == src_w);
	end

	// shared relax unit: one saturating add and one compare
	logic                     du_reach, ex;
	logic signed [DIST_W-1:0] du_dist, cand;
	logic signed [DIST_W:0]   sum;
	logic [SW-1:0]            w_raw;
	logic                     better, neg_hit;
	always_comb begin
		du_reach = d_rdata[DW-1];
		du_dist = d_rdata[DW-2 -: DIST_W];
		ex = e_rdata[EW-1];
		w_raw = e_rdata[SW-1:0];
		sum = {du_dist[DIST_W-1], du_dist} + {{(DIST_W+1-SW){w_raw[SW-1]}}, w_raw};
		if (sum[DIST_W] != sum[DIST_W-1]) begin
			cand = sum[DIST_W] ? DIST_MIN : DIST_MAX;
		end else begin
			cand = sum[DIST_W-1:0];
		end
		better = ex && du_reach && (!cur_reach_q || (cand < cur_dist_q));
		neg_hit = ex && du_reach && cur_reach_q && (cand < cur_dist_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == {EAW{1'b1}}) state_d = ST_IDLE;
			ST_IDLE: if (item.valid && item.func == FUNC_RUN) state_d = ST_INIT;
			ST_INIT: begin
				if (v_last) state_d = (n_eff == NW'(1)) ? ST_CHECK : ST_RELAX;
			end
			ST_RELAX: if (k_done && v_last && round_last) state_d = ST_CHECK;
			ST_CHECK: if (k_done && v_last) state_d = neg_q ? ST_NEG : ST_EM_RD;
			ST_EM_RD: state_d = ST_EM_LD;
			ST_EM_LD: state_d = ST_WAIT;
			ST_NEG: state_d = ST_WAIT;
			ST_WAIT: if (result.ready) state_d = out_last_q ? ST_IDLE : ST_EM_RD;
			default: state_d = ST_CLEAR;
		endcase
	end

	// memory ports and handshake
	always_comb begin
		item.ready = 1'b0;
		e_we = 1'b0;
		e_waddr = clr_q;
		e_wdata = '0;
		e_raddr = {u_iss, v_q};
		d_we = 1'b0;
		d_waddr = {1'b0, v_q};
		d_wdata = '0;
		d_raddr = {lay_q, v_q};
		unique case (state_q)
			ST_CLEAR: e_we = 1'b1;
			ST_IDLE: begin
				item.ready = 1'b1;
				if (item.valid && item.func == FUNC_LOAD && edge_in_range) begin
					e_we = 1'b1;
					e_waddr = {from_w[VW-1:0], to_w[VW-1:0]};
					e_wdata = {item.edge_present, item.edge_weight[SW-1:0]};
				end
			end
			ST_INIT: begin
				d_we = 1'b1;
				d_wdata = {is_src, {DIST_W{1'b0}}, is_src ? v_q : {VW{1'b0}}};
			end
			ST_RELAX, ST_CHECK: begin
				if (issue && k_q != '0) d_raddr = {lay_q, u_iss};
				if (state_q == ST_RELAX && k_done) begin
					d_we = 1'b1;
					d_waddr = {~lay_q, v_q};
					d_wdata = {cur_reach_q, cur_dist_q, cur_pred_q};
				end
			end
			ST_EM_RD, ST_EM_LD, ST_NEG, ST_WAIT: ;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			vc_q <= VC_RESET;
			clr_q <= '0;
			v_q <= '0;
			k_q <= '0;
			r_q <= '0;
			lay_q <= 1'b0;
			src_q <= '0;
			neg_q <= 1'b0;
			pv_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) vc_q <= pwdata[CFG_W-1:0];
			pv_s1 <= (state_q == ST_RELAX || state_q == ST_CHECK) && issue;
			if (pv_s1 && !phead_s1 && state_q == ST_CHECK && neg_hit) neg_q <= 1'b1;
			unique case (state_q)
				ST_CLEAR: clr_q <= clr_q + EAW'(1);
				ST_IDLE: begin
					if (item.valid && item.func == FUNC_RUN) begin
						src_q <= item.source_vertex;
						v_q <= '0;
						neg_q <= 1'b0;
					end
				end
				ST_INIT: begin
					v_q <= v_last ? '0 : v_q + VW'(1);
					k_q <= '0;
					r_q <= '0;
					lay_q <= 1'b0;
				end
				ST_RELAX, ST_CHECK: begin
					if (k_done) begin
						k_q <= '0;
						if (v_last) begin
							v_q <= '0;
							if (state_q == ST_RELAX) begin
								lay_q <= ~lay_q;
								r_q <= r_q + VW'(1);
							end
						end else begin
							v_q <= v_q + VW'(1);
						end
					end else begin
						k_q <= k_q + KW'(1);
					end
				end
				ST_EM_LD, ST_NEG: out_valid_q <= 1'b1;
				ST_WAIT: begin
					if (result.ready) begin
						out_valid_q <= 1'b0;
						v_q <= v_q + VW'(1);
					end
				end
				ST_EM_RD: ;
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		phead_s1 <= (k_q == '0);
		pu_s1 <= u_iss;
		if (pv_s1) begin
			if (phead_s1) begin
				cur_reach_q <= du_reach;
				cur_dist_q <= du_dist;
				cur_pred_q <= d_rdata[VW-1:0];
			end else if (state_q == ST_RELAX && better) begin
				cur_reach_q <= 1'b1;
				cur_dist_q <= cand;
				cur_pred_q <= pu_s1;
			end
		end
		if (state_q == ST_EM_LD) begin
			out_vertex_q <= v_w[VTX_W-1:0];
			out_reach_q <= du_reach;
			out_dist_q <= du_reach ? du_dist : '0;
			out_pred_q <= du_reach ? pred_w[VTX_W-1:0] : '0;
			out_neg_q <= 1'b0;
			out_last_q <= v_last;
		end else if (state_q == ST_NEG) begin
			out_vertex_q <= '0;
			out_reach_q <= 1'b0;
			out_dist_q <= '0;
			out_pred_q <= '0;
			out_neg_q <= 1'b1;
			out_last_q <= 1'b1;
		end
	end

	assign result.valid = out_valid_q;
	assign result.vertex = out_vertex_q;
	assign result.distance = out_dist_q;
	assign result.reachable = out_reach_q;
	assign result.predecessor = out_pred_q;
	assign result.negative_cycle = out_neg_q;
	assign result.last = out_last_q;

	`BFSP_ASSERT_IMP(a_idle_no_result, item.ready, !result.valid,
		"input ready while a result is pending")
	`BFSP_ASSERT_IMP(a_neg_is_last, result.valid && result.negative_cycle, result.last,
		"negative cycle beat not marked last")
	`BFSP_ASSERT_IMP(a_pipe_in_sweep, pv_s1, state_q == ST_RELAX || state_q == ST_CHECK,
		"relax pipe active outside a sweep")
	`BFSP_ASSERT_IMP(a_layer_split, state_q == ST_RELAX && d_we, d_waddr[VW] != lay_q,
		"relax write hits the layer being read")
	`BFSP_ASSERT_NXT(a_next_vertex, state_q == ST_WAIT && result.ready && !out_last_q,
		state_q == ST_EM_RD, "emit did not advance to next vertex")
endmodule

### tb/tb_scoreboard.sv
// Shortest path predictor and result checker for the Bellman-Ford block.
`timescale 1ns / 1ps
package tb_scoreboard_pkg;
	import bfsp_pkg::*;

	typedef struct packed {
		logic [VTX_W-1:0]         vertex;
		logic signed [DIST_W-1:0] distance;
		logic                     reachable;
		logic [VTX_W-1:0]         predecessor;
		logic                     negative_cycle;
		logic                     last;
	} path_result_t;

	class path_scoreboard;
		bit has_edge [256];
		int weight [256];
		int n_vertices;
		path_result_t pending_paths [$];
		int errors;

		function new();
			n_vertices = 16;
			errors = 0;
			foreach (has_edge[i]) has_edge[i] = 0;
			foreach (weight[i]) weight[i] = 0;
		endfunction

		function void set_vertex_count(logic [CFG_W-1:0] val);
			n_vertices = val;
			if (n_vertices < 1) n_vertices = 1;
			if (n_vertices > 16) n_vertices = 16;
		endfunction

		function int clamp_dist(longint x);
			if (x > 1048575) return 1048575;
			if (x < -1048576) return -1048576;
			return int'(x);
		endfunction

		function void note_item(logic func, logic [3:0] from_v, logic [3:0] to_v,
				logic signed [15:0] w, logic present, logic [3:0] src);
			int d_prev [16];
			int d_cur [16];
			bit r_prev [16];
			bit r_cur [16];
			int pred [16];
			int a;
			int cand;
			path_result_t res;
			if (func == FUNC_LOAD) begin
				a = from_v * 16 + to_v;
				has_edge[a] = present;
				weight[a] = w;
				return;
			end
			for (int v = 0; v < 16; v++) begin
				d_prev[v] = 0;
				d_cur[v] = 0;
				r_prev[v] = (v < n_vertices) && (v == src);
				pred[v] = (v == src) ? src : 0;
			end
			for (int r = 1; r < n_vertices; r++) begin
				for (int v = 0; v < n_vertices; v++) begin
					d_cur[v] = d_prev[v];
					r_cur[v] = r_prev[v];
					for (int u = 0; u < n_vertices; u++) begin
						a = u * 16 + v;
						if (has_edge[a] && r_prev[u]) begin
							cand = clamp_dist(longint'(d_prev[u]) + weight[a]);
							if (!r_cur[v] || cand < d_cur[v]) begin
								d_cur[v] = cand;
								r_cur[v] = 1;
								pred[v] = u;
							end
						end
					end
				end
				for (int v = 0; v < n_vertices; v++) begin
					d_prev[v] = d_cur[v];
					r_prev[v] = r_cur[v];
				end
			end
			for (int v = 0; v < n_vertices; v++)
				for (int u = 0; u < n_vertices; u++) begin
					a = u * 16 + v;
					if (has_edge[a] && r_prev[u] && r_prev[v] &&
							clamp_dist(longint'(d_prev[u]) + weight[a]) < d_prev[v]) begin
						res = '0;
						res.negative_cycle = 1;
						res.last = 1;
						pending_paths.push_back(res);
						return;
					end
				end
			for (int v = 0; v < n_vertices; v++) begin
				res = '0;
				res.vertex = VTX_W'(v);
				if (r_prev[v]) begin
					res.distance = DIST_W'(d_prev[v]);
					res.reachable = 1;
					res.predecessor = VTX_W'(pred[v]);
				end
				res.last = (v + 1 == n_vertices);
				pending_paths.push_back(res);
			end
		endfunction

		function void check_result(path_result_t got);
			path_result_t exp_r;
			if (pending_paths.size() == 0) begin
				$error("unexpected result beat vertex %0d", got.vertex);
				errors++;
				return;
			end
			exp_r = pending_paths.pop_front();
			if (got.vertex !== exp_r.vertex) begin
				$error("vertex: expected %0d, got %0d", exp_r.vertex, got.vertex);
				errors++;
			end
			if (got.distance !== exp_r.distance) begin
				$error("distance: expected %0d, got %0d", exp_r.distance, got.distance);
				errors++;
			end
			if (got.reachable !== exp_r.reachable) begin
				$error("reachable: expected %0b, got %0b", exp_r.reachable, got.reachable);
				errors++;
			end
			if (got.predecessor !== exp_r.predecessor) begin
				$error("predecessor: expected %0d, got %0d", exp_r.predecessor,
					got.predecessor);
				errors++;
			end
			if (got.negative_cycle !== exp_r.negative_cycle) begin
				$error("negative_cycle: expected %0b, got %0b", exp_r.negative_cycle,
					got.negative_cycle);
				errors++;
			end
			if (got.last !== exp_r.last) begin
				$error("last: expected %0b, got %0b", exp_r.last, got.last);
				errors++;
			end
		endfunction
	endclass
endpackage

### tb/tb_top.sv
// Top of the testbench for the Bellman-Ford shortest path block.
`timescale 1ns / 1ps
module tb_top;
	import bfsp_pkg::*;
	import tb_scoreboard_pkg::*;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	bfsp_item_if item_ch();
	bfsp_result_if result_ch();

	bellman_ford_shortest_paths dut (
		.clk(clk), .arst_n(arst_n), .item(item_ch.sink), .result(result_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	path_scoreboard paths;
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_off;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("FAIL");
		$finish;
	end

	// Drive ready and check accepted result beats.
	always @(posedge clk) begin
		path_result_t got;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				got.vertex = result_ch.vertex;
				got.distance = result_ch.distance;
				got.reachable = result_ch.reachable;
				got.predecessor = result_ch.predecessor;
				got.negative_cycle = result_ch.negative_cycle;
				got.last = result_ch.last;
				paths.check_result(got);
			end
			result_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic write_vertex_count(logic [CFG_W-1:0] val);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {REG_VERTEX_COUNT, 2'b00};
		pwdata <= 32'(val);
		@(posedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		paths.set_vertex_count(val);
	endtask

	// Hold valid after a beat; the next beat, an idle cycle or drain drops it.
	task automatic send_item(logic func, logic [3:0] from_v, logic [3:0] to_v,
			logic [15:0] w, logic present, logic [3:0] src);
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 0;
			@(posedge clk);
		end
		item_ch.valid <= 1;
		item_ch.func <= func;
		item_ch.from_vertex <= from_v;
		item_ch.to_vertex <= to_v;
		item_ch.edge_weight <= w;
		item_ch.edge_present <= present;
		item_ch.source_vertex <= src;
		do @(posedge clk); while (!item_ch.ready);
		paths.note_item(func, from_v, to_v, w, present, src);
	endtask

	task automatic load_edge(int u, int v, int w, bit present);
		send_item(FUNC_LOAD, 4'(u), 4'(v), 16'(w), present, 4'($urandom));
	endtask

	task automatic run_from(int src);
		send_item(FUNC_RUN, 4'($urandom), 4'($urandom), 16'($urandom), 1'($urandom),
			4'(src));
	endtask

	task automatic drain();
		item_ch.valid <= 0;
		while (paths.pending_paths.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Random graph on n vertices, mostly well-formed, then a run.
	task automatic random_phase(int n, int loads);
		int w;
		for (int i = 0; i < loads; i++) begin
			case ($urandom_range(3))
				0: w = $urandom;
				1: w = $urandom_range(20) - 3;
				default: w = $urandom_range(100);
			endcase
			load_edge($urandom_range(n - 1), $urandom_range(n - 1), w, $urandom_range(3) != 0);
		end
		run_from($urandom_range(3) == 0 ? $urandom_range(15) : $urandom_range(n - 1));
	endtask

	initial begin
		paths = new();
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		item_ch.valid = 0; item_ch.func = FUNC_LOAD; item_ch.from_vertex = '0;
		item_ch.to_vertex = '0; item_ch.edge_weight = '0; item_ch.edge_present = 0;
		item_ch.source_vertex = '0;
		result_ch.ready = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;

		// Directed: empty graph at reset size, chain of largest positive weights, ties.
		run_from(0);
		drain();
		write_vertex_count(4);
		load_edge(0, 1, 16'h7FFF, 1);
		load_edge(1, 2, 16'h7FFF, 1);
		load_edge(2, 3, 16'h7FFF, 1);
		load_edge(15, 15, 16'hFFFF, 1);
		load_edge(0, 2, 16'h8000, 0);
		load_edge(0, 3, 5, 1);
		load_edge(1, 3, -16'sd32762, 1);
		load_edge(2, 3, 16'h8000, 1);
		run_from(0);
		run_from(3);
		run_from(15);
		drain();
		// Negative cycle, then undo it.
		load_edge(3, 1, 16'h8000, 1);
		run_from(0);
		load_edge(3, 1, 0, 0);
		load_edge(0, 1, 0, 1);
		load_edge(0, 2, 0, 1);
		load_edge(1, 3, 0, 1);
		load_edge(2, 3, 0, 1);
		run_from(0);
		drain();
		write_vertex_count(0);
		run_from(0);
		run_from(1);
		drain();
		write_vertex_count(31);
		run_from(15);
		drain();

		// Long receiver hold while runs and a load stack up.
		write_vertex_count(3);
		hold_off = 1;
		fork
			begin
				repeat (400) @(posedge clk);
				hold_off = 0;
			end
			begin
				run_from(0);
				run_from(1);
				load_edge(0, 1, 7, 1);
			end
		join
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 51; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 51; end
				default: begin send_idle_pct = 13; recv_stall_pct = 13; end
			endcase
			write_vertex_count(ph == 7 ? 16 : (ph == 0 ? 2 : $urandom_range(2, 8)));
			for (int k = 0; k < 2; k++)
				random_phase(paths.n_vertices, 7);
			drain();
		end
		if (paths.errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
